// ===== design/lsfd_pkg.sv =====
`default_nettype none
package lsfd_pkg;

    localparam int PORT_COUNT    = 8;
    localparam int TABLE_ENTRIES = 64;
    localparam int MAC_W         = 48;
    localparam int MCAST_BIT     = 40;

    // configuration register indexes
    localparam logic [1:0] CFG_HUB_MODE     = 2'd0;
    localparam logic [1:0] CFG_PORT_ENABLED = 2'd1;
    localparam logic [1:0] CFG_PORT_GROUPS  = 2'd2;

    typedef struct packed {
        logic [2:0]       ingress_port;
        logic [MAC_W-1:0] source_mac;
        logic [MAC_W-1:0] dest_mac;
    } in_t;

    typedef struct packed {
        logic [7:0] egress_mask;
        logic       was_flooded;
        logic       table_full;
    } out_t;

    typedef struct packed {
        logic        hub;
        logic [7:0]  enabled;
        logic [31:0] groups;
    } cfg_t;

    // lookup token walking down the cell row
    typedef struct packed {
        logic             valid;
        logic [2:0]       ing;
        logic [MAC_W-1:0] src;
        logic [MAC_W-1:0] dst;
        logic             learn_pending;
        logic             dst_hit;
        logic [2:0]       dst_port;
    } token_t;

    function automatic logic [3:0] group_of(logic [31:0] groups, logic [2:0] port);
        logic [4:0] sh;
        sh = {port, 2'b00};
        return groups[sh +: 4];
    endfunction

    function automatic out_t decide(token_t t, cfg_t c);
        out_t       r;
        logic [3:0] gi;
        logic [3:0] gt;
        logic [7:0] m;
        logic [7:0] live;
        logic       flood;
        gi    = group_of(c.groups, t.ing);
        gt    = group_of(c.groups, t.dst_port);
        m     = '0;
        live  = '0;
        flood = !t.dst_hit || t.dst[MCAST_BIT] || c.hub;
        for (int q = 0; q < PORT_COUNT; q++) begin
            live[q] = c.enabled[q];
        end
        if (flood) begin
            for (int q = 0; q < 8; q++) begin
                m[q] = (3'(q) != t.ing)
                    && !((gi != 4'd0) && (group_of(c.groups, 3'(q)) == gi));
            end
        end else if (gt == 4'd0) begin
            m[t.dst_port] = 1'b1;
        end else if (gt != gi) begin
            for (int q = 0; q < 8; q++) begin
                m[q] = (group_of(c.groups, 3'(q)) == gt);
            end
        end
        r.egress_mask = m & live;
        r.was_flooded = flood;
        r.table_full  = t.learn_pending;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/lsfd_cell.sv =====
`default_nettype none
module lsfd_cell (
    input  wire             clk,
    input  wire             rst_n,
    input  lsfd_pkg::cfg_t   cfg,
    input  lsfd_pkg::token_t tok_in,
    output lsfd_pkg::token_t tok_out
);
    import lsfd_pkg::*;

    logic             valid_reg, valid_next;
    logic [MAC_W-1:0] addr_reg, addr_next;
    logic [2:0]       port_reg, port_next;
    logic             tvalid_reg;
    token_t           tok_reg, tok_next;
    logic [3:0]       gi;

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        port_next  = port_reg;
        tok_next   = tok_in;
        gi         = group_of(cfg.groups, tok_in.ing);
        if (tok_in.valid && tok_in.learn_pending) begin
            if (valid_reg && addr_reg == tok_in.src) begin
                tok_next.learn_pending = 1'b0;
                if (port_reg != tok_in.ing
                    && (gi == 4'd0 || gi != group_of(cfg.groups, port_reg))) begin
                    port_next = tok_in.ing;
                end
            end else if (!valid_reg) begin
                // entries fill from the front, so the first free cell ends the table
                tok_next.learn_pending = 1'b0;
                valid_next = 1'b1;
                addr_next  = tok_in.src;
                port_next  = tok_in.ing;
            end
        end
        if (tok_in.valid && !tok_in.dst_hit && valid_next && addr_next == tok_in.dst) begin
            tok_next.dst_hit  = 1'b1;
            tok_next.dst_port = port_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            tvalid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        port_reg <= port_next;
        tok_reg  <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tvalid_reg;
    end

endmodule
`default_nettype wire

// ===== design/learning_switch_forward_decision.sv =====
// path: the input beat passes the register in each table cell, then the pending register, then the output register
// one header at a time walks the cell row; a stalled output holds off the next header
// the next header is taken once the previous result sits in the output register
// reset: asynchronous active low, clears all entry valid bits, config and handshake state
`default_nettype none
module learning_switch_forward_decision (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  lsfd_pkg::in_t   in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output lsfd_pkg::out_t  out_data,
    input  wire            cfg_valid,
    output logic           cfg_ready,
    input  wire [1:0]      cfg_index,
    input  wire [31:0]     cfg_data
);
    import lsfd_pkg::*;

    // config registers
    cfg_t   cfg_reg, cfg_next;

    // handshake and result staging
    logic   busy_reg, busy_next;
    logic   pend_valid_reg, pend_valid_next;
    token_t pend_tok_reg;
    logic   out_valid_reg, out_valid_next;
    out_t   out_data_reg, out_data_next;
    logic   in_beat;
    logic   load_out;

    // token row: tok[0] feeds cell 0, tok[TABLE_ENTRIES] leaves the last cell
    token_t                   tok [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] chain_valid;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg;
    assign in_beat   = in_valid && in_ready;
    assign load_out  = pend_valid_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        tok[0].valid         = in_beat;
        tok[0].ing           = in_data.ingress_port;
        tok[0].src           = in_data.source_mac;
        tok[0].dst           = in_data.dest_mac;
        // multicast sources are never learned
        tok[0].learn_pending = !in_data.source_mac[MCAST_BIT];
        tok[0].dst_hit       = 1'b0;
        tok[0].dst_port      = 3'd0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            lsfd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cfg     (cfg_reg),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
            assign chain_valid[gi] = tok[gi+1].valid;
        end
    endgenerate

    // config writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HUB_MODE:     cfg_next.hub     = cfg_data[0];
                CFG_PORT_ENABLED: cfg_next.enabled = cfg_data[7:0];
                CFG_PORT_GROUPS:  cfg_next.groups  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // busy from accept until the result lands in the output register
    always_comb
    begin
        busy_next = busy_reg;
        if (in_beat) begin
            busy_next = 1'b1;
        end else if (load_out) begin
            busy_next = 1'b0;
        end
        pend_valid_next = pend_valid_reg;
        if (tok[TABLE_ENTRIES].valid) begin
            pend_valid_next = 1'b1;
        end else if (load_out) begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = decide(pend_tok_reg, cfg_reg);
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg        <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[TABLE_ENTRIES].valid) begin
            pend_tok_reg <= tok[TABLE_ENTRIES];
        end
        out_data_reg <= out_data_next;
    end

    // at most one header in flight between accept and output
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({chain_valid, pend_valid_reg}) <= 1)
        else $error("more than one header in flight");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (chain_valid == '0) && !pend_valid_reg)
        else $error("ready while a header is in the row");

    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok[TABLE_ENTRIES].valid |-> busy_reg && !pend_valid_reg)
        else $error("token leaves the row while not busy");

    a_load_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && !busy_reg)
        else $error("result load did not release the input");

endmodule
`default_nettype wire
